FILE: hdl/i2r_pkg.sv
// Shared types, constants and helpers for the integer to radix digit converter.
`default_nettype none
package i2r_pkg;

	localparam int RADIX_W = 6;
	localparam int DIGIT_W = 6;
	localparam int CHAR_W  = 7;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] RADIX_MIN   = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX   = 6'd36;
	localparam logic [DIGIT_W-1:0] DEC_DIGITS  = 6'd10;
	localparam logic [CHAR_W-1:0]  ASCII_ZERO  = 7'd48;
	localparam logic [CHAR_W-1:0]  ASCII_A     = 7'd65;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_POP,
		ST_EMIT
	} i2r_state_t;

	// controller -> datapath
	typedef struct packed {
		logic load;   // latch input value, clear stack
		logic step;   // one quotient bit of the divider
		logic pop;    // read top of stack into the output register
	} i2r_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic last_bit;    // divider is on its final quotient bit
		logic quot_zero;   // quotient after this step is zero
		logic last_digit;  // output register holds the final digit
	} i2r_stat_t;

	function automatic logic [CHAR_W-1:0] digit_to_ascii(input logic [DIGIT_W-1:0] d);
		logic [CHAR_W-1:0] c;
		if (d < DEC_DIGITS) begin
			c = ASCII_ZERO + {1'b0, d};
		end else begin
			c = ASCII_A + {1'b0, d - DEC_DIGITS};
		end
		return c;
	endfunction

endpackage
`default_nettype wire

FILE: hdl/i2r_dpath.sv
// Datapath: radix register, bit-serial divider, digit stack and output register.
`default_nettype none
module i2r_dpath #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_BITS  = 31
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire i2r_pkg::i2r_cmd_t             cmd,
	output i2r_pkg::i2r_stat_t                 stat,
	input  wire logic [VALUE_BITS-1:0]         value,
	input  wire logic                          cfg_we,
	input  wire logic [i2r_pkg::RADIX_W-1:0]   cfg_data,
	output logic [i2r_pkg::DIGIT_W-1:0]        digit_value,
	output logic [i2r_pkg::CHAR_W-1:0]         digit_char
);
	import i2r_pkg::*;

	localparam int AW = $clog2(STACK_DEPTH);
	localparam int CW = $clog2(STACK_DEPTH + 1);
	localparam int BW = $clog2(VALUE_BITS);

	logic [RADIX_W-1:0]    radix_q;
	logic [VALUE_BITS-1:0] quot_q;
	logic [DIGIT_W-1:0]    rem_q;
	logic [BW-1:0]         bcnt_q;
	logic [CW-1:0]         sp_q;
	logic [DIGIT_W-1:0]    rd_q;
	logic                  last_q;
	logic [DIGIT_W-1:0]    mem [STACK_DEPTH];

	logic [DIGIT_W:0]      trial;
	logic                  qbit;
	logic [DIGIT_W-1:0]    rem_next;
	logic [VALUE_BITS-1:0] quot_next;
	logic [CW-1:0]         sp_dec;
	logic                  push;
	logic                  room;

	// restoring division, one quotient bit per cycle
	always_comb begin
		trial     = {rem_q, quot_q[VALUE_BITS-1]};
		qbit      = (trial >= {1'b0, radix_q});
		rem_next  = qbit ? DIGIT_W'(trial - {1'b0, radix_q}) : trial[DIGIT_W-1:0];
		quot_next = {quot_q[VALUE_BITS-2:0], qbit};
		sp_dec    = sp_q - CW'(1);
		room      = (sp_q < CW'(STACK_DEPTH));
		push      = cmd.step && stat.last_bit && room;
	end

	assign stat.last_bit   = (bcnt_q == BW'(VALUE_BITS - 1));
	assign stat.quot_zero  = (quot_next == '0);
	assign stat.last_digit = last_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
		end else if (cfg_we) begin
			if (cfg_data < RADIX_MIN) begin
				radix_q <= RADIX_MIN;
			end else if (cfg_data > RADIX_MAX) begin
				radix_q <= RADIX_MAX;
			end else begin
				radix_q <= cfg_data;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			quot_q <= '0;
			rem_q  <= '0;
			bcnt_q <= '0;
			sp_q   <= '0;
			last_q <= 1'b0;
		end else begin
			if (cmd.load) begin
				quot_q <= value;
				rem_q  <= '0;
				bcnt_q <= '0;
				sp_q   <= '0;
				last_q <= 1'b0;
			end else if (cmd.step) begin
				quot_q <= quot_next;
				if (stat.last_bit) begin
					// digit done; restart on the new quotient
					rem_q  <= '0;
					bcnt_q <= '0;
					if (room) begin
						sp_q <= sp_q + CW'(1);
					end
				end else begin
					rem_q  <= rem_next;
					bcnt_q <= bcnt_q + BW'(1);
				end
			end else if (cmd.pop) begin
				sp_q   <= sp_dec;
				last_q <= (sp_q == CW'(1));
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[sp_q[AW-1:0]] <= rem_next;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pop) begin
			rd_q <= mem[sp_dec[AW-1:0]];
		end
	end

	assign digit_value = rd_q;
	assign digit_char  = digit_to_ascii(rd_q);

	a_sp_bound: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= CW'(STACK_DEPTH))
		else $error("digit stack pointer beyond depth");

	a_rem_lt_radix: assert property (@(posedge clk) disable iff (!arst_n)
		rem_q < radix_q)
		else $error("partial remainder not below radix");

	a_last_empty: assert property (@(posedge clk) disable iff (!arst_n)
		last_q |-> (sp_q == '0))
		else $error("last digit flagged with digits left on stack");

endmodule
`default_nettype wire

FILE: hdl/i2r_ctrl.sv
// Controller: sequences load, division, stack pops and digit handshakes.
`default_nettype none
module i2r_ctrl (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	output logic                    out_valid,
	input  wire logic               out_ready,
	output i2r_pkg::i2r_cmd_t       cmd,
	input  wire i2r_pkg::i2r_stat_t stat
);
	import i2r_pkg::*;

	i2r_state_t state_q;
	i2r_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = ST_DIV;
				end
			end
			ST_DIV: begin
				cmd.step = 1'b1;
				if (stat.last_bit && stat.quot_zero) begin
					state_d = ST_POP;
				end
			end
			ST_POP: begin
				cmd.pop = 1'b1;
				state_d = ST_EMIT;
			end
			ST_EMIT: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = stat.last_digit ? ST_IDLE : ST_POP;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	a_cmd_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(cmd))
		else $error("more than one datapath command at once");

	a_accept_div: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_DIV))
		else $error("accepted transaction did not start division");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && stat.last_digit) |=> (state_q == ST_IDLE))
		else $error("final digit taken but controller not idle");

endmodule
`default_nettype wire

FILE: hdl/integer_to_radix_digits.sv
// Top level of the integer to radix digit converter.
`default_nettype none
// Converts one unsigned VALUE_BITS-bit integer into digits of the base held in
// the radix register (2..36, reset 10; writes below 2 store 2, above 36 store 36).
// Digits leave most significant first, one output transaction each, as a value,
// an ASCII character ('0'-'9', 'A'-'Z') and a last flag on the final digit; zero
// gives the single digit '0'. One conversion at a time: in_ready is high only
// while idle. A shared restoring divider produces one quotient bit per cycle, and
// the remainders go onto a digit stack memory with a registered read port. Each
// digit is popped in ST_POP and then offered in ST_EMIT until out_ready takes it.
// If VALUE_BITS exceeds STACK_DEPTH only the STACK_DEPTH least significant
// digits are kept. Configuration writes are always taken.
module integer_to_radix_digits #(
	parameter int STACK_DEPTH = 32,
	parameter int VALUE_BITS  = 31
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         in_valid,
	output logic                              in_ready,
	input  wire logic [VALUE_BITS-1:0]        value,
	output logic                              out_valid,
	input  wire logic                         out_ready,
	output logic [i2r_pkg::DIGIT_W-1:0]       digit_value,
	output logic [i2r_pkg::CHAR_W-1:0]        digit_char,
	output logic                              last,
	input  wire logic                         cfg_valid,
	output logic                              cfg_ready,
	input  wire logic [i2r_pkg::RADIX_W-1:0]  cfg_data
);
	import i2r_pkg::*;

	i2r_cmd_t  cmd;
	i2r_stat_t stat;

	assign cfg_ready = 1'b1;
	assign last      = stat.last_digit;

	i2r_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	i2r_dpath #(
		.STACK_DEPTH (STACK_DEPTH),
		.VALUE_BITS  (VALUE_BITS)
	) u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.value       (value),
		.cfg_we      (cfg_valid && cfg_ready),
		.cfg_data    (cfg_data),
		.digit_value (digit_value),
		.digit_char  (digit_char)
	);

endmodule
`default_nettype wire

FILE: verif/tb_integer_to_radix_digits.sv
// Self-checking testbench for integer_to_radix_digits: random and directed conversions.
module tb_integer_to_radix_digits;
	import i2r_pkg::*;

	localparam int VBITS = 31;
	localparam int QUIET_LIMIT = 8000;
	localparam logic [VBITS-1:0] VALUE_ALL = {VBITS{1'b1}};

	typedef struct {
		logic [VBITS-1:0] num;
		logic             drain;   // hold off until all digits of earlier values are out
	} value_item_t;

	typedef struct {
		logic [DIGIT_W-1:0] num;
		logic [CHAR_W-1:0]  code;
		logic               is_last;
	} digit_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_ready;
	logic [VBITS-1:0]     value = '0;
	logic                 out_valid;
	logic                 out_ready = 1'b0;
	logic [DIGIT_W-1:0]   digit_value;
	logic [CHAR_W-1:0]    digit_char;
	logic                 last;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [RADIX_W-1:0]   cfg_data = '0;

	value_item_t          values_waiting[$];
	digit_t               digits_due[$];
	logic [RADIX_W-1:0]   radix_now = RADIX_RESET;
	logic                 steady = 1'b0;
	int                   mismatches = 0;
	int                   quiet_cycles = 0;

	integer_to_radix_digits DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.value       (value),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.digit_value (digit_value),
		.digit_char  (digit_char),
		.last        (last),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_data    (cfg_data)
	);

	always #4 clk = ~clk;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $time, msg);
		mismatches++;
	endtask

	function automatic logic [RADIX_W-1:0] clamp_radix(input logic [RADIX_W-1:0] r);
		logic [RADIX_W-1:0] c;
		c = r;
		if (c < RADIX_MIN) c = RADIX_MIN;
		if (c > RADIX_MAX) c = RADIX_MAX;
		return c;
	endfunction

	// Divide down by the current radix, then emit remainders most significant first.
	task automatic convert_value(input logic [VBITS-1:0] v);
		logic [DIGIT_W-1:0] stack [32];
		logic [VBITS-1:0]   q;
		logic [DIGIT_W-1:0] d;
		digit_t             dg;
		int                 depth;
		q = v;
		depth = 0;
		if (q == 0) begin
			stack[0] = '0;
			depth = 1;
		end
		while (q != 0) begin
			stack[depth] = DIGIT_W'(q % radix_now);
			q = q / radix_now;
			depth++;
		end
		for (int i = depth - 1; i >= 0; i--) begin
			d = stack[i];
			dg.num = d;
			dg.code = (d < DEC_DIGITS) ? ASCII_ZERO + d : ASCII_A + (d - DEC_DIGITS);
			dg.is_last = (i == 0);
			digits_due.push_back(dg);
		end
	endtask

	// Sender: one value per transaction, valid held until taken.
	always @(posedge clk or negedge arst_n) begin : sender
		value_item_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			value <= '0;
		end else if (!in_valid || in_ready) begin
			if (in_valid) convert_value(value);
			if (values_waiting.size() != 0 && (steady || $urandom_range(99) >= 14)
			    && !(values_waiting[0].drain && digits_due.size() != 0)) begin
				nxt = values_waiting.pop_front();
				in_valid <= 1'b1;
				value <= nxt.num;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Receiver: random back-pressure and field checks.
	always @(posedge clk or negedge arst_n) begin : receiver
		digit_t want;
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if (out_valid && out_ready) begin
				if (digits_due.size() == 0) begin
					report_mismatch($sformatf("digit %0d with nothing pending", digit_value));
				end else begin
					want = digits_due.pop_front();
					if (digit_value !== want.num)
						report_mismatch($sformatf("digit_value %0d, want %0d",
							digit_value, want.num));
					if (digit_char !== want.code)
						report_mismatch($sformatf("digit_char %0d, want %0d",
							digit_char, want.code));
					if (last !== want.is_last)
						report_mismatch($sformatf("last %b, want %b", last, want.is_last));
				end
			end
			out_ready <= steady || ($urandom_range(99) >= 14);
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
				quiet_cycles <= 0;
			else
				quiet_cycles <= quiet_cycles + 1;
			if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Regression FAIL");
				$finish;
			end
		end
	end

	task automatic add_value(input logic [VBITS-1:0] v, input logic drain);
		value_item_t it;
		it.num = v;
		it.drain = drain;
		values_waiting.push_back(it);
	endtask

	task automatic load_radix(input logic [RADIX_W-1:0] r);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= r;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		radix_now = clamp_radix(r);
	endtask

	task automatic wait_idle();
		do @(negedge clk); while (values_waiting.size() != 0 || in_valid || digits_due.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [VBITS-1:0] pick_value(input logic [RADIX_W-1:0] r);
		longint unsigned p;
		int k;
		case ($urandom_range(0, 5))
			0: return VBITS'($urandom_range(0, 2 * r));
			1: begin
				// around a power of the radix, where digit count changes
				p = 1;
				k = $urandom_range(1, 30);
				while (k > 0 && p * r <= VALUE_ALL) begin
					p = p * r;
					k--;
				end
				return VBITS'(VALUE_ALL & (p + $urandom_range(0, 2) - 1));
			end
			2: return VBITS'($urandom() >> $urandom_range(0, 31));
			3: return VBITS'(VALUE_ALL - $urandom_range(0, 3));
			default: return VBITS'($urandom());
		endcase
	endfunction

	initial begin
		logic [RADIX_W-1:0] r;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;

		// reset radix is decimal
		add_value('0, 1'b0);
		add_value(1, 1'b0);
		add_value(9, 1'b0);
		add_value(10, 1'b0);
		add_value(VALUE_ALL, 1'b0);
		add_value(31'h4000_0000, 1'b0);
		add_value(12345, 1'b0);
		wait_idle();

		load_radix(6'd0);   // clamps up to 2
		add_value('0, 1'b0);
		add_value(1, 1'b0);
		add_value(VALUE_ALL, 1'b0);
		add_value(31'h5555_5555, 1'b0);
		add_value(31'h2AAA_AAAA, 1'b0);
		wait_idle();

		load_radix(6'd1);
		add_value(31'h4000_0000, 1'b0);
		wait_idle();

		load_radix(6'd63);  // clamps down to 36
		add_value(35, 1'b0);
		add_value(36, 1'b0);
		add_value(1295, 1'b0);
		add_value(VALUE_ALL, 1'b0);
		wait_idle();

		load_radix(6'd37);
		add_value(1296, 1'b0);
		wait_idle();

		load_radix(6'd16);
		add_value(31'hFF, 1'b0);
		add_value(31'h00AB_CDEF, 1'b0);
		wait_idle();

		load_radix(6'd36);
		add_value('0, 1'b0);
		wait_idle();

		for (int ph = 0; ph < 8; ph++) begin
			case (ph)
				0: r = 6'd2;
				1: r = 6'd36;
				2, 5: r = RADIX_W'($urandom_range(0, 63));
				default: r = RADIX_W'($urandom_range(2, 36));
			endcase
			load_radix(r);
			steady = (ph == 4);
			for (int i = 0; i < 24; i++)
				add_value(pick_value(radix_now), $urandom_range(0, 9) == 0);
			wait_idle();
		end
		steady = 1'b0;

		repeat (40) @(posedge clk);
		if (mismatches == 0 && digits_due.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

FILE: files.f
hdl/i2r_pkg.sv
hdl/i2r_dpath.sv
hdl/i2r_ctrl.sv
hdl/integer_to_radix_digits.sv
verif/tb_integer_to_radix_digits.sv
